// ===== sv/mfbc_pkg.sv =====
// shared constants and bit-level functions for the byte feistel cipher
// no dependencies; used by mfbc_core and mini_feistel_byte_cipher

package mfbc_pkg;

   localparam int BLOCK_W  = 8;
   localparam int HALF_W   = 4;
   localparam int RKEY_W   = 6;
   localparam int ROUNDS   = 3;
   localparam int ROT_W    = 2;

   typedef logic [BLOCK_W-1:0] byte_type;
   typedef logic [HALF_W-1:0]  half_type;
   typedef logic [RKEY_W-1:0]  rkey_type;

   // per-round left rotation of each key half, applied cumulatively
   localparam logic [ROT_W-1:0] KEY_ROT [ROUNDS] = '{2'd1, 2'd2, 2'd1};

   // des s1, index is {row, column}
   localparam logic [3:0] SBOX1 [64] = '{
      4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
      4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
      4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
      4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
      4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
      4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
      4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13
   };

   function automatic half_type rot_half(input half_type h, input logic [ROT_W-1:0] s);
      logic [2*HALF_W-1:0] dbl;
      dbl = {h, h} << s;
      return dbl[2*HALF_W-1:HALF_W];
   endfunction

   // key positions 6,2,4,3,8,1
   function automatic rkey_type pick_round_key(input byte_type k);
      return {k[2], k[6], k[4], k[5], k[0], k[7]};
   endfunction

   // expansion positions 3,4,2,3,2,1, sbox lookup, p-box 3,1,4,2
   function automatic half_type round_f(input half_type r, input rkey_type rk);
      rkey_type x;
      half_type s;
      x = {r[1], r[0], r[2], r[1], r[2], r[3]} ^ rk;
      s = SBOX1[{x[5], x[0], x[4:1]}];
      return {s[1], s[3], s[0], s[2]};
   endfunction

endpackage

// ===== sv/mfbc_core.sv =====
// three-round feistel datapath with key schedule, purely combinational
// depends on mfbc_pkg

module mfbc_core (
   input  mfbc_pkg::byte_type plain_byte,
   input  mfbc_pkg::byte_type cipher_key,
   output mfbc_pkg::byte_type cipher_byte
);

   mfbc_pkg::half_type kl [mfbc_pkg::ROUNDS+1];
   mfbc_pkg::half_type kr [mfbc_pkg::ROUNDS+1];
   mfbc_pkg::half_type l  [mfbc_pkg::ROUNDS+1];
   mfbc_pkg::half_type r  [mfbc_pkg::ROUNDS+1];

   always_comb begin
      kl[0] = cipher_key[7:4];
      kr[0] = cipher_key[3:0];
      l[0]  = plain_byte[7:4];
      r[0]  = plain_byte[3:0];
      for (int i = 0; i < mfbc_pkg::ROUNDS; i++) begin
         kl[i+1] = mfbc_pkg::rot_half(kl[i], mfbc_pkg::KEY_ROT[i]);
         kr[i+1] = mfbc_pkg::rot_half(kr[i], mfbc_pkg::KEY_ROT[i]);
         l[i+1]  = r[i];
         r[i+1]  = l[i] ^ mfbc_pkg::round_f(r[i],
                      mfbc_pkg::pick_round_key({kl[i+1], kr[i+1]}));
      end
   end

   assign cipher_byte = {l[mfbc_pkg::ROUNDS], r[mfbc_pkg::ROUNDS]};

endmodule

// ===== sv/mini_feistel_byte_cipher.sv =====
// top level of the byte feistel cipher: key register, input and result stages
// depends on mfbc_pkg and mfbc_core

// Encrypts one 8-bit block per transfer with a three-round reduced-DES
// feistel network under the 8-bit key in the key register. One byte is
// accepted every cycle while req_stall is low; each byte passes the input
// register, the cipher logic and the result register before its result is
// offered. The cipher logic is combinational, between those two registers,
// and the input side keeps taking bytes while a result waits, stalling only
// when both stages are full and the result side stalls. Write the key only
// while no bytes are in flight.

module mini_feistel_byte_cipher (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mfbc_pkg::byte_type req_plain_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mfbc_pkg::byte_type rsp_cipher_byte,
   input  logic               csr_wr_en,
   input  mfbc_pkg::byte_type csr_wr_data
);

   mfbc_pkg::byte_type key_ff;
   logic               in_vld_ff;
   mfbc_pkg::byte_type in_byte_ff;
   logic               out_vld_ff;
   mfbc_pkg::byte_type out_byte_ff;
   mfbc_pkg::byte_type out_byte_in;
   logic               out_ready;
   logic               in_ready;
   logic               req_xfer;

   assign out_ready = !out_vld_ff || !rsp_stall;
   assign in_ready  = !in_vld_ff || out_ready;
   assign req_stall = !in_ready;
   assign req_xfer  = req_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en) begin
         key_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_plain_byte;
      end
   end

   mfbc_core u_core (
      .plain_byte  (in_byte_ff),
      .cipher_key  (key_ff),
      .cipher_byte (out_byte_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_ready) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && in_vld_ff) begin
         out_byte_ff <= out_byte_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_cipher_byte = out_byte_ff;

   // stall only when both stages are full and the result side holds
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff && rsp_stall))
      else $error("input stalled while a stage was free");

   // accepted byte lands in the input stage
   a_in_capture: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (in_vld_ff && in_byte_ff == $past(req_plain_byte)))
      else $error("accepted byte not captured");

   // stage advance carries the cipher result
   a_out_capture: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && out_ready) |=> (out_vld_ff && out_byte_ff == $past(out_byte_in)))
      else $error("result stage did not take the cipher output");

   // a result is not dropped while stalled
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rsp_stall) |=> (out_vld_ff && $stable(out_byte_ff)))
      else $error("stalled result lost");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!in_vld_ff && !out_vld_ff))
      else $error("stages not empty after reset");

endmodule
